### design/udba_pkg.sv
`default_nettype none

package udba_pkg;

  // Field widths.
  localparam int unsigned LevelW  = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned CfgIdxW = 1;

  // Register reset values in milliseconds.
  localparam logic [DelayW-1:0] LongPressDelayRst = 16'd450;
  localparam logic [DelayW-1:0] RepeatPeriodRst   = 16'd200;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegLongPressDelay = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRepeatPeriod   = 1'b1;

  // Button level codes.
  typedef enum logic [LevelW-1:0] {
    LVL_RELEASED      = 2'd0,
    LVL_JUST_RELEASED = 2'd1,
    LVL_JUST_PRESSED  = 2'd2,
    LVL_HELD          = 2'd3
  } level_e;

  // Action codes.
  typedef enum logic [ActionW-1:0] {
    ACT_NOTHING = 2'd0,
    ACT_INCR    = 2'd1,
    ACT_DECR    = 2'd2,
    ACT_RESET   = 2'd3
  } action_e;

  // Press mode, one-hot.
  typedef enum logic [2:0] {
    MODE_INITIAL     = 3'b001,
    MODE_LONG        = 3'b010,
    MODE_AFTER_RESET = 3'b100
  } mode_e;

endpackage

`default_nettype wire

### design/up_down_button_autorepeat.sv
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------------
// poll in  | in_valid_i / in_ready_o    | incr_level_i, decr_level_i, now_ms_i,
//          |                            | incr_held_ms_i, decr_held_ms_i
// action   | out_valid_o / out_ready_i  | action_o
// config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// Each poll word yields one action word, held first in the input register and then
// in the result register. One poll is accepted every cycle while the action output
// does not stall; the decode and its 32-bit subtract and compares sit between them.
// Reset clears press mode, repeat mark and valid flags and loads the default delays.
// When the action output stalls, the input register fills and in_ready_o drops.

module up_down_button_autorepeat (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [udba_pkg::LevelW-1:0]   incr_level_i,
  input  wire logic [udba_pkg::LevelW-1:0]   decr_level_i,
  input  wire logic [udba_pkg::TimeW-1:0]    now_ms_i,
  input  wire logic [udba_pkg::TimeW-1:0]    incr_held_ms_i,
  input  wire logic [udba_pkg::TimeW-1:0]    decr_held_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [udba_pkg::ActionW-1:0]       action_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [udba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [udba_pkg::DelayW-1:0]   cfg_data_i
);
  import udba_pkg::*;

  logic [DelayW-1:0] long_delay_q;
  logic [DelayW-1:0] period_q;

  logic              s1_valid_q;
  level_e            incr_lvl_q;
  level_e            decr_lvl_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  incr_held_q;
  logic [TimeW-1:0]  decr_held_q;

  mode_e             mode_q, mode_d;
  logic [TimeW-1:0]  mark_q, mark_d;
  action_e           act_d;
  action_e           act_q;
  logic              out_valid_q;

  logic              out_free;
  logic              fire;
  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  sel_held;
  action_e           step_act;
  logic              period_due;
  logic              held_long;
  logic              one_held;

  // Handshake control: the result register frees up when empty or taken.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_delay_q <= LongPressDelayRst;
      period_q     <= RepeatPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLongPressDelay: long_delay_q <= cfg_data_i;
        RegRepeatPeriod:   period_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      incr_lvl_q  <= level_e'(incr_level_i);
      decr_lvl_q  <= level_e'(decr_level_i);
      now_q       <= now_ms_i;
      incr_held_q <= incr_held_ms_i;
      decr_held_q <= decr_held_ms_i;
    end
  end

  // Timing comparisons for the single-held case; increment takes precedence.
  assign one_held   = (incr_lvl_q == LVL_HELD) || (decr_lvl_q == LVL_HELD);
  assign sel_held   = (incr_lvl_q == LVL_HELD) ? incr_held_q : decr_held_q;
  assign step_act   = (incr_lvl_q == LVL_HELD) ? ACT_INCR : ACT_DECR;
  assign elapsed    = now_q - mark_q;
  assign period_due = elapsed >= {{(TimeW-DelayW){1'b0}}, period_q};
  assign held_long  = sel_held >= {{(TimeW-DelayW){1'b0}}, long_delay_q};

  // Priority decode of the button pair.
  always_comb begin
    act_d  = ACT_NOTHING;
    mode_d = mode_q;
    mark_d = mark_q;
    if (incr_lvl_q == LVL_RELEASED && decr_lvl_q == LVL_RELEASED) begin
      act_d = ACT_NOTHING;
    end else if ((decr_lvl_q == LVL_JUST_RELEASED && incr_lvl_q == LVL_RELEASED) ||
                 (incr_lvl_q == LVL_JUST_RELEASED && decr_lvl_q == LVL_RELEASED)) begin
      mode_d = MODE_INITIAL;
    end else if (incr_lvl_q == LVL_JUST_PRESSED && decr_lvl_q == LVL_JUST_PRESSED) begin
      act_d  = ACT_RESET;
      mode_d = MODE_AFTER_RESET;
    end else if (incr_lvl_q == LVL_JUST_PRESSED) begin
      if (decr_lvl_q == LVL_HELD) begin
        act_d  = ACT_RESET;
        mode_d = MODE_AFTER_RESET;
      end else begin
        act_d = ACT_INCR;
      end
    end else if (decr_lvl_q == LVL_JUST_PRESSED) begin
      if (incr_lvl_q == LVL_HELD) begin
        act_d  = ACT_RESET;
        mode_d = MODE_AFTER_RESET;
      end else begin
        act_d = ACT_DECR;
      end
    end else if (incr_lvl_q == LVL_HELD && decr_lvl_q == LVL_HELD) begin
      act_d = ACT_NOTHING;
    end else if (mode_q != MODE_AFTER_RESET && one_held) begin
      // Long press: repeat on the period, or enter auto-repeat once held long enough.
      if (mode_q == MODE_LONG) begin
        if (period_due) begin
          mark_d = mark_q + {{(TimeW-DelayW){1'b0}}, period_q};
          act_d  = step_act;
        end
      end else if (held_long) begin
        mode_d = MODE_LONG;
        mark_d = now_q;
        act_d  = step_act;
      end
    end
  end

  // Press state advances with each decoded poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INITIAL;
      mark_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      mark_q <= mark_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      act_q <= act_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = act_q;

  // A stalled result holds the press state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(mark_q) && $stable(mode_q))
    else $error("press state changed while the result was stalled");

  // A reset action always leaves the block in the after-reset mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && act_d == ACT_RESET |=> mode_q == MODE_AFTER_RESET)
    else $error("reset action without after-reset mode");

  // The repeat mark only moves when the block is in or enters long-press mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mark_d != mark_q |=> mode_q == MODE_LONG)
    else $error("repeat mark moved outside long-press mode");

  // Backpressure reaches the input only through a full pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
